@@ src/usems_pkg.sv @@
// Shared codes and cell control types for the unique-set extract-min sort table.
package usems_pkg;

    localparam int unsigned VALUE_W  = 8;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SORT   = 2'd2;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_LOAD,
        CELL_CLOSE,
        CELL_SORT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_ctl;

endpackage

@@ src/usems_cell.sv @@
// One table cell: holds an entry and trades it with its neighbors.
module usems_cell
    import usems_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned IW  = 4,
    parameter int unsigned CW  = 5
) (
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [CW-1:0]      i_fill,
    input  logic [IW-1:0]      i_pos,
    input  logic [VALUE_W-1:0] i_head,
    input  logic [VALUE_W-1:0] i_prev,
    input  logic [VALUE_W-1:0] i_next,
    input  logic [VALUE_W-1:0] i_load,
    output logic [VALUE_W-1:0] o_val
);

    localparam logic [CW-1:0] L_IDX  = CW'(IDX);
    localparam logic [CW-1:0] L_IDX1 = CW'(IDX + 1);

    logic [VALUE_W-1:0] r_val;
    logic [VALUE_W-1:0] n_val;
    logic               w_has_next;
    logic               w_in_use;
    logic               w_lower;

    assign w_has_next = (L_IDX1 < i_fill);
    assign w_in_use   = (L_IDX < i_fill);
    // lower member of a compare-exchange pair in this phase
    assign w_lower    = (i_ctl.phase == L_IDX[0]);

    always_comb begin
        n_val = r_val;
        case (i_ctl.op)
            CELL_ROT: begin
                if (w_has_next) begin
                    n_val = i_next;
                end else if (L_IDX1 == i_fill) begin
                    n_val = i_head;
                end
            end
            CELL_LOAD: begin
                if (L_IDX == i_fill) begin
                    n_val = i_load;
                end
            end
            CELL_CLOSE: begin
                if (L_IDX >= CW'(i_pos) && w_has_next) begin
                    n_val = i_next;
                end
            end
            CELL_SORT: begin
                if (w_lower && w_has_next) begin
                    n_val = (i_next < r_val) ? i_next : r_val;
                end else if (!w_lower && (IDX != 0) && w_in_use) begin
                    n_val = (i_prev > r_val) ? i_prev : r_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

@@ src/unique_set_extract_min_sort.sv @@
// Insert into a non-empty table and remove scan it by rotating it past the head cell;
// list streams it by rotation; sort runs compare-exchange steps, then streams it.
// One operation at a time: input ready only while idle, so a new operation is taken
// once the last has loaded its result; streaming stalls while the output is held.
// Reset clears the entry count, the controller and the output valid; cell contents
// are not cleared and are never read before being written.
module unique_set_extract_min_sort
    import usems_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [OP_W-1:0]                    i_op,
    input  logic [VALUE_W-1:0]                 i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [STATUS_W-1:0]                o_status,
    output logic [VALUE_W-1:0]                 o_item,
    output logic [$clog2(ENTRIES + 1)-1:0]     o_count,
    output logic                               o_last
);

    localparam int unsigned IW = $clog2(ENTRIES);
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_CLOSE,
        S_SORT,
        S_LIST,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [OP_W-1:0]       r_op;
    logic [VALUE_W-1:0]    r_value;
    logic [CW-1:0]         r_fill;
    logic [IW-1:0]         r_cnt;
    logic [VALUE_W-1:0]    r_min;
    logic [IW-1:0]         r_pos;
    logic                  r_dup;
    logic [STATUS_W-1:0]   r_res_status;
    logic [VALUE_W-1:0]    r_res_item;

    logic [VALUE_W-1:0]    w_val [ENTRIES];
    logic [VALUE_W-1:0]    w_head;
    t_cell_ctl             w_ctl;
    logic                  w_out_free;
    logic                  w_out_load;
    logic                  w_cnt_last;
    logic                  w_dup_now;
    logic                  w_take;
    logic                  w_accept;

    assign w_head     = w_val[0];
    assign w_out_free = !o_valid || i_ready;
    assign w_out_load = w_out_free && ((r_state == S_LIST) || (r_state == S_EMIT));
    assign w_cnt_last = (CW'(r_cnt) == (r_fill - CW'(1)));
    assign w_dup_now  = r_dup || (w_head == r_value);
    assign w_take     = (r_cnt == '0) || (w_head < r_min);
    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;

    always_comb begin
        w_ctl.op    = CELL_HOLD;
        w_ctl.phase = r_cnt[0];
        case (r_state)
            S_SCAN:   w_ctl.op = CELL_ROT;
            S_INSERT: w_ctl.op = CELL_LOAD;
            S_CLOSE:  w_ctl.op = CELL_CLOSE;
            S_SORT:   w_ctl.op = CELL_SORT;
            S_LIST:   w_ctl.op = w_out_free ? CELL_ROT : CELL_HOLD;
            default:  w_ctl.op = CELL_HOLD;
        endcase
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic [VALUE_W-1:0] w_prev;
        logic [VALUE_W-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_val[g-1];
        end
        if (g == ENTRIES - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_val[g+1];
        end

        usems_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_fill (r_fill),
            .i_pos  (r_pos),
            .i_head (w_head),
            .i_prev (w_prev),
            .i_next (w_next),
            .i_load (r_value),
            .o_val  (w_val[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_pos   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op         <= i_op;
                        r_value      <= i_value;
                        r_cnt        <= '0;
                        r_dup        <= 1'b0;
                        r_res_status <= ST_EMPTY;
                        r_res_item   <= '0;
                        if (i_op == OP_INSERT) begin
                            r_state <= (r_fill == '0) ? S_INSERT : S_SCAN;
                        end else if (r_fill == '0) begin
                            r_state <= S_EMIT;
                        end else if (i_op == OP_REMOVE) begin
                            r_state <= S_SCAN;
                        end else if (i_op == OP_SORT) begin
                            r_state <= S_SORT;
                        end else begin
                            r_state <= S_LIST;
                        end
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + IW'(1);
                    r_dup <= w_dup_now;
                    if (w_take) begin
                        r_min <= w_head;
                        r_pos <= r_cnt;
                    end
                    if (w_cnt_last) begin
                        if (r_op == OP_REMOVE) begin
                            r_state <= S_CLOSE;
                        end else if (w_dup_now) begin
                            r_res_status <= ST_DUP;
                            r_state      <= S_EMIT;
                        end else if (r_fill == CW'(ENTRIES)) begin
                            r_res_status <= ST_FULL;
                            r_state      <= S_EMIT;
                        end else begin
                            r_state <= S_INSERT;
                        end
                    end
                end
                S_INSERT: begin
                    r_fill       <= r_fill + CW'(1);
                    r_res_status <= ST_OK;
                    r_state      <= S_EMIT;
                end
                S_CLOSE: begin
                    r_fill       <= r_fill - CW'(1);
                    r_res_status <= ST_OK;
                    r_res_item   <= r_min;
                    r_state      <= S_EMIT;
                end
                S_SORT: begin
                    if (w_cnt_last) begin
                        r_cnt   <= '0;
                        r_state <= S_LIST;
                    end else begin
                        r_cnt <= r_cnt + IW'(1);
                    end
                end
                S_LIST: begin
                    if (w_out_free) begin
                        o_status <= ST_OK;
                        o_item   <= w_head;
                        o_count  <= r_fill;
                        o_last   <= w_cnt_last;
                        r_cnt    <= r_cnt + IW'(1);
                        if (w_cnt_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        o_status <= r_res_status;
                        o_item   <= r_res_item;
                        o_count  <= r_fill;
                        o_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/usems_checker.sv @@
// Port-level checks for the unique-set extract-min sort table, bound to the top level.
module usems_checker
    import usems_pkg::*;
#(
    parameter int unsigned ENTRIES = 16
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [STATUS_W-1:0]            o_status,
    input logic [VALUE_W-1:0]             o_item,
    input logic [$clog2(ENTRIES + 1)-1:0] o_count,
    input logic                           o_last
);

    localparam int unsigned CW = $clog2(ENTRIES + 1);

    // a held result keeps its payload until the transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_item)
            && $stable(o_count) && $stable(o_last)))
        else $error("result changed while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count <= CW'(ENTRIES)))
        else $error("count above table size");

    a_fail_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_last && (o_item == '0)))
        else $error("rejected operation must give one empty result");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_EMPTY)) |-> (o_count == '0))
        else $error("empty status with nonzero count");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind unique_set_extract_min_sort usems_checker #(.ENTRIES(ENTRIES)) u_usems_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_status (o_status),
    .o_item   (o_item),
    .o_count  (o_count),
    .o_last   (o_last)
);
